// ===== src/block_bitmap_allocator_macros.svh =====
// Assertion macros for the bitmap block allocator.
// Used by block_bitmap_allocator.sv; empty bodies when SYNTHESIS is defined.
`ifndef BLOCK_BITMAP_ALLOCATOR_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BBA_ASSERT_IMP(lbl, ante, cons, msg)
`define BBA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/bba_pkg.sv =====
// Shared types and constants of the bitmap block allocator.
// No dependencies.
package bba_pkg;

    localparam int MAX_BLOCKS_DEF    = 4096;
    localparam int MAP_WORD_BITS_DEF = 32;

    localparam int BLOCK_W  = 12;
    localparam int DISK_W   = 13;
    localparam int STATUS_W = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [DISK_W-1:0] DISK_BLOCKS_RESET = 13'd4096;

    // register index, taken from paddr[2]
    localparam logic REG_DISK_BLOCKS = 1'b0;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_NO_FREE      = 2'd1,
        ST_ALREADY_FREE = 2'd2,
        ST_OUT_OF_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_FDIV,
        S_FMOD,
        S_FREE
    } state_t;

endpackage

// ===== src/block_bitmap_allocator.sv =====
// Allocate: scans the map one word per cycle through the map RAM read port, from
// word 0 up to the last word in range, and takes the lowest free bit that it finds.
// Free: two-step word/bit split, one RAM read, then write back if the block was set.
// busy falls with the done beat, so the next command can start in that cycle.
// Reset clears disk_blocks to 4096 and the map at once through per-word valid
// flags; no clearing pass.
`include "block_bitmap_allocator_macros.svh"
// Top level: command port, APB register, map RAM and scan/free sequencer.
// Depends on bba_pkg and bba_ram.
module block_bitmap_allocator
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS    = MAX_BLOCKS_DEF,
    parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                op,
    input  logic [BLOCK_W-1:0]  block_number,
    output logic                done,
    output logic [BLOCK_W-1:0]  allocated_block,
    output logic [STATUS_W-1:0] status,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int WB     = MAP_WORD_BITS;
    localparam int WORDS  = (MAX_BLOCKS + WB - 1) / WB;
    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW     = $clog2(WB);
    localparam int BLK_W  = $clog2(MAX_BLOCKS);
    localparam int SIZE_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W  = (SIZE_W > DISK_W) ? SIZE_W : DISK_W;
    localparam int SH     = BLK_W + 7;
    localparam logic [SH-1:0]    RECIP   = SH'((64'd1 << SH) / WB);
    localparam logic [CMP_W-1:0] WB_C    = CMP_W'(WB);
    localparam logic [CMP_W-1:0] MAX_C   = CMP_W'(MAX_BLOCKS);
    localparam logic [BLK_W-1:0] WB_BLK  = BLK_W'(WB);
    localparam logic [BW:0]      WB_LIM  = (BW+1)'(WB);

    state_t state_reg, state_next;

    logic [DISK_W-1:0]   disk_blocks_reg;
    logic [BLOCK_W-1:0]  blk_reg, blk_next;
    logic [AW-1:0]       word_reg, word_next;
    logic [BW-1:0]       bit_reg, bit_next;
    logic [CMP_W-1:0]    base_reg, base_next;
    logic [BLK_W-1:0]    q_est_reg, q_est_next;
    logic [WORDS-1:0]    valid_reg;

    logic                done_reg, done_next;
    logic [BLOCK_W-1:0]  allocated_block_reg, allocated_block_next;
    status_t             status_reg, status_next;

    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [WB-1:0]       mem_wdata, mem_rdata;

    logic                cfg_wr;
    logic                accept;
    logic [CMP_W-1:0]    size_eff;
    logic [CMP_W-1:0]    blk_ext;
    logic [BLK_W-1:0]    blk_idx;
    logic [WB-1:0]       cur_word;
    logic [CMP_W-1:0]    rem;
    logic [BW:0]         in_word;
    logic [WB-1:0]       bound_mask;
    logic [WB-1:0]       free_bits;
    logic                found;
    logic [BW-1:0]       pick;
    logic                last_word;
    logic [WB-1:0]       pick_hot, bit_hot;
    logic [BLK_W+SH-1:0] q_prod;
    logic [BLK_W-1:0]    q_base, q_diff, q_fix;
    logic [BW-1:0]       r_fix;
    logic [CMP_W-1:0]    got;

    bba_ram #(
        .WIDTH (WB),
        .DEPTH (WORDS)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DISK_BLOCKS);
    assign prdata = (paddr[2] == REG_DISK_BLOCKS) ? PDATA_W'(disk_blocks_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_blocks_reg <= DISK_BLOCKS_RESET;
        end
        else if (cfg_wr)
        begin
            disk_blocks_reg <= pwdata[DISK_W-1:0];
        end
    end

    assign accept   = start && (state_reg == S_IDLE);
    assign busy     = (state_reg != S_IDLE);
    assign size_eff = (CMP_W'(disk_blocks_reg) > MAX_C) ? MAX_C : CMP_W'(disk_blocks_reg);
    assign blk_ext  = CMP_W'(blk_reg);
    assign blk_idx  = blk_ext[BLK_W-1:0];

    // never-written words read as all free
    assign cur_word = valid_reg[word_reg] ? mem_rdata : '0;

    // scan of one word
    assign rem       = (size_eff > base_reg) ? (size_eff - base_reg) : '0;
    assign last_word = (rem <= WB_C);
    assign in_word   = last_word ? rem[BW:0] : WB_LIM;

    always_comb
    begin
        for (int j = 0; j < WB; j++)
        begin
            bound_mask[j] = ((BW+1)'(j) < in_word);
        end
    end

    assign free_bits = ~cur_word & bound_mask;
    assign found     = |free_bits;

    always_comb
    begin
        pick = '0;
        for (int j = WB - 1; j >= 0; j--)
        begin
            if (free_bits[j])
            begin
                pick = BW'(j);
            end
        end
    end

    assign pick_hot = WB'(1) << pick;
    assign bit_hot  = WB'(1) << bit_reg;
    assign got      = base_reg + CMP_W'(pick);

    // block to word/bit: reciprocal estimate, then one correction
    assign q_prod = (BLK_W+SH)'(blk_idx) * (BLK_W+SH)'(RECIP);
    assign q_base = BLK_W'(q_est_reg * WB_BLK);
    assign q_diff = blk_idx - q_base;
    assign q_fix  = (q_diff >= WB_BLK) ? (q_est_reg + BLK_W'(1)) : q_est_reg;
    assign r_fix  = (q_diff >= WB_BLK) ? BW'(q_diff - WB_BLK) : BW'(q_diff);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (op == OP_FREE) ? S_FDIV : S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                if (found || last_word)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FDIV:  state_next = S_FMOD;
            S_FMOD:  state_next = S_FREE;
            S_FREE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        blk_next             = blk_reg;
        word_next            = word_reg;
        bit_next             = bit_reg;
        base_next            = base_reg;
        q_est_next           = q_est_reg;
        done_next            = 1'b0;
        allocated_block_next = allocated_block_reg;
        status_next          = status_reg;
        mem_we               = 1'b0;
        mem_waddr            = word_reg;
        mem_wdata            = cur_word;
        mem_re               = 1'b0;
        mem_raddr            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    blk_next  = block_number;
                    word_next = '0;
                    base_next = '0;
                    mem_re    = (op == OP_ALLOC);
                end
            end
            S_ALLOC:
            begin
                if (found)
                begin
                    mem_we               = 1'b1;
                    mem_wdata            = cur_word | pick_hot;
                    done_next            = 1'b1;
                    allocated_block_next = got[BLOCK_W-1:0];
                    status_next          = ST_OK;
                end
                else if (last_word)
                begin
                    done_next            = 1'b1;
                    allocated_block_next = '0;
                    status_next          = ST_NO_FREE;
                end
                else
                begin
                    word_next = word_reg + AW'(1);
                    base_next = base_reg + WB_C;
                    mem_re    = 1'b1;
                    mem_raddr = word_reg + AW'(1);
                end
            end
            S_FDIV:
            begin
                q_est_next = q_prod[BLK_W+SH-1:SH];
            end
            S_FMOD:
            begin
                word_next = q_fix[AW-1:0];
                bit_next  = r_fix;
                mem_re    = 1'b1;
                mem_raddr = q_fix[AW-1:0];
            end
            S_FREE:
            begin
                done_next            = 1'b1;
                allocated_block_next = '0;
                if (blk_ext >= size_eff)
                begin
                    status_next = ST_OUT_OF_RANGE;
                end
                else if (!cur_word[bit_reg])
                begin
                    status_next = ST_ALREADY_FREE;
                end
                else
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = cur_word & ~bit_hot;
                    status_next = ST_OK;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (mem_we)
            begin
                valid_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg             <= blk_next;
        word_reg            <= word_next;
        bit_reg             <= bit_next;
        base_reg            <= base_next;
        q_est_reg           <= q_est_next;
        allocated_block_reg <= allocated_block_next;
        status_reg          <= status_next;
    end

    assign done            = done_reg;
    assign allocated_block = allocated_block_reg;
    assign status          = status_reg;

    `BBA_ASSERT_IMP(a_done_idle, done_reg, state_reg == S_IDLE, "result beat while busy")
    `BBA_ASSERT_NXT(a_accept_busy, accept, busy, "accepted command did not raise busy")
    `BBA_ASSERT_IMP(a_we_state, mem_we, (state_reg == S_ALLOC) || (state_reg == S_FREE), "map write outside update")
    `BBA_ASSERT_IMP(a_fail_zero, done_reg && (status_reg != ST_OK), allocated_block_reg == '0, "failed beat carries a block number")

endmodule

// ===== src/bba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
